FILE: rtl/mbss_pkg.sv
// Shared types and constants for the masked byte signature scan.
`default_nettype none

package mbss_pkg;

    localparam int MAX_PATTERN_BYTES = 24;
    localparam int OFFSET_BITS       = 32;
    localparam int SIG_REG_BYTES     = 24;
    localparam int CFG_DATA_BITS     = 64;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int LEN_BITS          = 5;
    localparam int MASK_BITS         = 24;
    localparam int RESULT_OFFSET_BITS  = 32;
    localparam int RESULT_ADDRESS_BITS = 64;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_MIDDLE = 3'd1,
        REG_PATTERN_HIGH   = 3'd2,
        REG_CARE_MASK      = 3'd3,
        REG_PATTERN_LENGTH = 3'd4,
        REG_BASE_ADDRESS   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic                           found;
        logic [RESULT_OFFSET_BITS-1:0]  match_offset;
        logic [RESULT_ADDRESS_BITS-1:0] match_address;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/mbss_cell.sv
// One window cell: holds one byte, passes it on, and checks its incoming byte.
`default_nettype none

module mbss_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mbss_pkg::cell_ctrl_t ctrl,
    input  wire logic [7:0]         din,
    input  wire logic [7:0]         expected,
    input  wire logic               care,
    output logic [7:0]              dout,
    output logic                    hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = 8'd0;
        end
        else if (ctrl.shift)
        begin
            byte_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // compare the byte that enters this cell on the current shift
    assign hit  = !care || (din == expected);
    assign dout = byte_reg;

endmodule

`default_nettype wire

FILE: rtl/mbss_result_fifo.sv
// Two-word result queue between the scan logic and the output channel.
`default_nettype none

module mbss_result_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mbss_pkg::result_t push_word,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mbss_pkg::result_t      head_word
);

    mbss_pkg::result_t entries_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign head_word = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/masked_byte_signature_scan_core.sv
// Top level of the masked byte signature scan.
// Takes one region byte per clock while in_ready is high: each accepted byte
// up to the region's match shifts into a row of MAX_PATTERN_BYTES cells, every
// cell checks its byte against the signature byte aligned to it, and the cell
// hits are ANDed with the byte count check in the same cycle. A result word (a
// match, or found clear at the region end) is written into a two-word output
// queue at the edge that accepts the byte and is offered on the output once it
// heads the queue; the offset subtract and the 64-bit base add sit in the
// accepting cycle, ahead of the queue. in_ready drops only while both queue
// words are waiting. No clearing pass after reset.
`default_nettype none

module masked_byte_signature_scan_core #(
    parameter int MAX_PATTERN_BYTES = mbss_pkg::MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = mbss_pkg::OFFSET_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [mbss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [mbss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          data_byte,
    input  wire logic                                end_of_region,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     found,
    output logic [mbss_pkg::RESULT_OFFSET_BITS-1:0]  match_offset,
    output logic [mbss_pkg::RESULT_ADDRESS_BITS-1:0] match_address
);

    localparam int LenCap = (MAX_PATTERN_BYTES < mbss_pkg::SIG_REG_BYTES) ?
                            MAX_PATTERN_BYTES : mbss_pkg::SIG_REG_BYTES;
    localparam int LenW   = mbss_pkg::LEN_BITS;
    localparam int AddrW  = mbss_pkg::RESULT_ADDRESS_BITS;

    // configuration registers
    logic [63:0]                    pattern_low_reg;
    logic [63:0]                    pattern_middle_reg;
    logic [63:0]                    pattern_high_reg;
    logic [mbss_pkg::MASK_BITS-1:0] care_mask_reg;
    logic [LenW-1:0]                pattern_length_reg;
    logic [63:0]                    base_address_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_middle_reg <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '1;
            pattern_length_reg <= LenW'(mbss_pkg::SIG_REG_BYTES);
            base_address_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mbss_pkg::REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                mbss_pkg::REG_PATTERN_MIDDLE: pattern_middle_reg <= cfg_data;
                mbss_pkg::REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                mbss_pkg::REG_CARE_MASK:
                    care_mask_reg <= cfg_data[mbss_pkg::MASK_BITS-1:0];
                mbss_pkg::REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[LenW-1:0];
                mbss_pkg::REG_BASE_ADDRESS:   base_address_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamped pattern length
    logic [LenW-1:0] len_eff;

    always_comb
    begin
        len_eff = pattern_length_reg;
        if (pattern_length_reg == '0)
        begin
            len_eff = LenW'(1);
        end
        else if (pattern_length_reg > LenW'(LenCap))
        begin
            len_eff = LenW'(LenCap);
        end
    end

    logic [7:0] sig_bytes [mbss_pkg::SIG_REG_BYTES];

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            sig_bytes[k]      = pattern_low_reg[k*8 +: 8];
            sig_bytes[k + 8]  = pattern_middle_reg[k*8 +: 8];
            sig_bytes[k + 16] = pattern_high_reg[k*8 +: 8];
        end
    end

    // scan state
    logic [OFFSET_BITS-1:0] bytes_seen_reg, bytes_seen_next;
    logic                   reported_reg, reported_next;

    logic                 accept;
    logic                 fifo_full;
    mbss_pkg::cell_ctrl_t cell_ctrl;
    logic [7:0]           cell_out [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] cell_hit;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;

    // signature position k sits len-1-k cells back in the row
    for (genvar i = 0; i < MAX_PATTERN_BYTES; i++)
    begin : g_cell
        logic            active;
        logic [LenW-1:0] pos;
        logic [7:0]      expected;
        logic            care;
        logic [7:0]      din;

        assign active   = (32'(len_eff) > 32'(i));
        assign pos      = len_eff - LenW'(1) - LenW'(i);
        assign expected = active ? sig_bytes[pos] : 8'd0;
        assign care     = active && care_mask_reg[pos];

        if (i == 0)
        begin : g_head
            assign din = data_byte;
        end
        else
        begin : g_link
            assign din = cell_out[i-1];
        end

        mbss_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .din      (din),
            .expected (expected),
            .care     (care),
            .dout     (cell_out[i]),
            .hit      (cell_hit[i])
        );
    end

    logic                   counted;
    logic [OFFSET_BITS-1:0] count_inc;
    logic [OFFSET_BITS-1:0] offset;
    logic [AddrW-1:0]       offset_wide;
    logic                   is_match;
    logic                   push;
    mbss_pkg::result_t      push_word;
    mbss_pkg::result_t      head_word;

    assign counted     = (bytes_seen_reg != '1);
    assign count_inc   = bytes_seen_reg + OFFSET_BITS'(1);
    // seen + 1 - len, taken from the registered count to keep the adder chain short
    assign offset      = bytes_seen_reg - OFFSET_BITS'(len_eff - LenW'(1));
    assign offset_wide = AddrW'(offset);
    assign is_match    = counted && (count_inc >= OFFSET_BITS'(len_eff)) && (&cell_hit);

    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        reported_next   = reported_reg;
        cell_ctrl       = '0;
        push            = 1'b0;
        push_word       = '0;
        if (accept)
        begin
            if (!reported_reg)
            begin
                cell_ctrl.shift = 1'b1;
                if (counted)
                begin
                    bytes_seen_next = count_inc;
                end
                if (is_match)
                begin
                    push                    = 1'b1;
                    push_word.found         = 1'b1;
                    push_word.match_offset  = offset_wide[mbss_pkg::RESULT_OFFSET_BITS-1:0];
                    push_word.match_address = base_address_reg + offset_wide;
                    reported_next           = 1'b1;
                end
                else if (end_of_region)
                begin
                    // region ended with no match: found clear, zero fields
                    push = 1'b1;
                end
            end
            if (end_of_region)
            begin
                cell_ctrl.clear = 1'b1;
                bytes_seen_next = '0;
                reported_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            reported_reg   <= 1'b0;
        end
        else
        begin
            bytes_seen_reg <= bytes_seen_next;
            reported_reg   <= reported_next;
        end
    end

    mbss_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (fifo_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head_word (head_word)
    );

    assign found         = head_word.found;
    assign match_offset  = head_word.match_offset;
    assign match_address = head_word.match_address;

endmodule

`default_nettype wire

FILE: tb/sv/mbss_scan_checker.sv
// Checker for the masked byte signature scan: predicts result words and compares them.
`timescale 1ns / 1ps

module mbss_scan_checker (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [mbss_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [mbss_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  logic                                     in_valid,
    input  logic                                     in_ready,
    input  logic [7:0]                               data_byte,
    input  logic                                     end_of_region,
    input  logic                                     out_valid,
    input  logic                                     out_ready,
    input  logic                                     found,
    input  logic [mbss_pkg::RESULT_OFFSET_BITS-1:0]  match_offset,
    input  logic [mbss_pkg::RESULT_ADDRESS_BITS-1:0] match_address,
    output int                                       fail_count,
    output int                                       pending,
    output int                                       scanned_count,
    output int                                       result_count,
    output int                                       match_count
);

    import mbss_pkg::*;

    localparam int WIN = MAX_PATTERN_BYTES;

    // shadow copy of the registers
    logic [8*SIG_REG_BYTES-1:0] signature;
    logic [MASK_BITS-1:0]       care;
    logic [LEN_BITS-1:0]        len_setting;
    logic [63:0]                base;

    // scan state
    logic [7:0]             recent [WIN];
    logic [OFFSET_BITS-1:0] seen;
    logic                   matched;

    result_t outcome_q [$];
    int      fails;
    int      scanned;
    int      results;
    int      hits;

    function automatic int active_length();
        int n;
        n = len_setting;
        if (n < 1)
            n = 1;
        if (n > WIN)
            n = WIN;
        if (n > SIG_REG_BYTES)
            n = SIG_REG_BYTES;
        return n;
    endfunction

    // signature byte k sits n-1-k words back
    function automatic logic window_hit(int n);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < n; k++)
            if (care[k] && recent[n-1-k] != signature[8*k +: 8])
                ok = 1'b0;
        return ok;
    endfunction

    task automatic clear_scan();
        foreach (recent[i])
            recent[i] = '0;
        seen    = '0;
        matched = 1'b0;
    endtask

    task automatic scan_word(input logic [7:0] b, input logic last);
        int                     n;
        logic                   counted;
        logic [OFFSET_BITS-1:0] offset;
        result_t                r;
        n = active_length();
        if (matched)
        begin
            // draining the rest of a region that already hit
            if (last)
                clear_scan();
        end
        else
        begin
            scanned++;
            for (int i = WIN - 1; i > 0; i--)
                recent[i] = recent[i-1];
            recent[0] = b;
            counted = (seen != '1);
            if (counted)
                seen++;
            if (counted && seen >= n && window_hit(n))
            begin
                offset          = seen - n;
                r.found         = 1'b1;
                r.match_offset  = offset;
                r.match_address = base + 64'(offset);
                outcome_q.push_back(r);
                if (last)
                    clear_scan();
                else
                    matched = 1'b1;
            end
            else if (last)
            begin
                r = '0;
                outcome_q.push_back(r);
                clear_scan();
            end
        end
    endtask

    task automatic check_result_word();
        result_t want;
        results++;
        if (found)
            hits++;
        if (outcome_q.size() == 0)
        begin
            $error("unexpected result word: found %0d offset %0d address %h",
                   found, match_offset, match_address);
            fails++;
        end
        else
        begin
            want = outcome_q.pop_front();
            if (found !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, found);
                fails++;
            end
            if (match_offset !== want.match_offset)
            begin
                $error("match_offset: expected %0d, got %0d", want.match_offset, match_offset);
                fails++;
            end
            if (match_address !== want.match_address)
            begin
                $error("match_address: expected %h, got %h", want.match_address, match_address);
                fails++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signature   = '0;
            care        = '1;
            len_setting = LEN_BITS'(24);
            base        = '0;
            clear_scan();
            outcome_q.delete();
            fails   = 0;
            scanned = 0;
            results = 0;
            hits    = 0;
            fail_count    <= 0;
            pending       <= 0;
            scanned_count <= 0;
            result_count  <= 0;
            match_count   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result_word();
            if (in_valid && in_ready)
                scan_word(data_byte, end_of_region);
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PATTERN_LOW:    signature[63:0]    = cfg_data;
                    REG_PATTERN_MIDDLE: signature[127:64]  = cfg_data;
                    REG_PATTERN_HIGH:   signature[191:128] = cfg_data;
                    REG_CARE_MASK:      care               = cfg_data[MASK_BITS-1:0];
                    REG_PATTERN_LENGTH: len_setting        = cfg_data[LEN_BITS-1:0];
                    REG_BASE_ADDRESS:   base               = cfg_data;
                    default: ;
                endcase
            end
            fail_count    <= fails;
            pending       <= outcome_q.size();
            scanned_count <= scanned;
            result_count  <= results;
            match_count   <= hits;
        end
    end

endmodule

FILE: tb/sv/masked_byte_signature_scan_core_tb.sv
// Testbench top for the masked byte signature scan: stimulus, stall control and verdict.
`timescale 1ns / 1ps

module masked_byte_signature_scan_core_tb;

    import mbss_pkg::*;

    localparam int ITEM_TARGET   = 1300;
    localparam int STALL_CYCLES  = 120;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 20000;

    // indexes past the register list, which the block must ignore
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_write;
    logic [CFG_INDEX_BITS-1:0]      cfg_index;
    logic [CFG_DATA_BITS-1:0]       cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [7:0]                     data_byte;
    logic                           end_of_region;
    logic                           out_valid;
    logic                           out_ready;
    logic                           found;
    logic [RESULT_OFFSET_BITS-1:0]  match_offset;
    logic [RESULT_ADDRESS_BITS-1:0] match_address;

    int fail_count;
    int pending;
    int scanned_count;
    int result_count;
    int match_count;

    bit steady     = 1'b0;
    bit hold_req   = 1'b0;
    bit hold_taken = 1'b0;
    int items_sent   = 0;
    int regions_sent = 0;
    int phases       = 0;

    // current signature, used to plant hits in the stimulus
    logic [8*SIG_REG_BYTES-1:0] plan_sig;
    logic [MASK_BITS-1:0]       plan_mask;
    int                         plan_len;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    masked_byte_signature_scan_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_region (end_of_region),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_offset  (match_offset),
        .match_address (match_address)
    );

    mbss_scan_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_region (end_of_region),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .match_offset  (match_offset),
        .match_address (match_address),
        .fail_count    (fail_count),
        .pending       (pending),
        .scanned_count (scanned_count),
        .result_count  (result_count),
        .match_count   (match_count)
    );

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_region <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // wait for every expected word, then catch any unexpected words still in flight
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic pick_settings(input int phase_no);
        logic [LEN_BITS-1:0]        len_reg;
        logic [MASK_BITS-1:0]       mask;
        logic [63:0]                base;
        logic [63:0]                word;
        logic [8*SIG_REG_BYTES-1:0] sig;
        case (phase_no % 6)
            0:       len_reg = 5'd31;
            1:       len_reg = 5'd0;
            2:       len_reg = 5'd24;
            3:       len_reg = 5'd25;
            default: len_reg = LEN_BITS'($urandom_range(1, 8));
        endcase
        plan_len = (len_reg == 0) ? 1 : (len_reg > 24) ? 24 : int'(len_reg);
        sig = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        // self-similar signatures give overlapping partial hits
        if ($urandom_range(0, 2) == 0)
            for (int k = 0; k < SIG_REG_BYTES; k++)
                sig[8*k +: 8] = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
        case ($urandom_range(0, 3))
            0:       mask = '1;
            1:       mask = '0;
            2:       mask = MASK_BITS'($urandom);
            default: mask = MASK_BITS'($urandom & $urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       base = '1;
            1:       base = '0;
            default: base = {$urandom, $urandom};
        endcase
        write_reg(REG_PATTERN_LOW, sig[63:0]);
        write_reg(REG_PATTERN_MIDDLE, sig[127:64]);
        write_reg(REG_PATTERN_HIGH, sig[191:128]);
        // junk in the unused upper bits of the narrow registers
        word = {$urandom, $urandom};
        word[MASK_BITS-1:0] = mask;
        write_reg(REG_CARE_MASK, word);
        word = {$urandom, $urandom};
        word[LEN_BITS-1:0] = len_reg;
        write_reg(REG_PATTERN_LENGTH, word);
        write_reg(REG_BASE_ADDRESS, base);
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, {$urandom, $urandom});
        cfg_write <= 1'b0;
        plan_sig  = sig;
        plan_mask = mask;
    endtask

    task automatic send_region();
        logic [7:0] bytes [0:127];
        int         size;
        int         spot;
        int         k;
        bit         alphabet;
        size = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 100) : $urandom_range(1, 32);
        alphabet = $urandom_range(0, 1);
        for (int i = 0; i < size; i++)
        begin
            k = $urandom_range(0, plan_len - 1);
            bytes[i] = (alphabet && $urandom_range(0, 3) != 0) ? plan_sig[8*k +: 8]
                                                               : 8'($urandom);
        end
        if (size >= plan_len && $urandom_range(0, 3) != 0)
        begin
            spot = $urandom_range(0, size - plan_len);
            for (k = 0; k < plan_len; k++)
                if (plan_mask[k])
                    bytes[spot+k] = plan_sig[8*k +: 8];
            // now and then break the planted copy
            if ($urandom_range(0, 4) == 0)
            begin
                k = $urandom_range(0, plan_len - 1);
                bytes[spot+k] = ~bytes[spot+k];
            end
        end
        for (int i = 0; i < size; i++)
            send_byte(bytes[i], i == size - 1);
        regions_sent++;
    endtask

    // result side: random hold-offs, plus one long stall on request
    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = steady ? 0 : $urandom_range(0, 4);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                out_ready <= 1'b1;
                @(posedge clk);
                while (!(out_valid && out_ready))
                    @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = REG_PATTERN_LOW;
        cfg_data      = '0;
        in_valid      = 1'b0;
        data_byte     = '0;
        end_of_region = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset signature is 24 zero bytes: a lone byte ends the region with no hit
        send_byte(8'hFF, 1'b1);
        settle();

        // length 0 acts as 1; match on the last word of the region
        write_reg(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFA5);
        write_reg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0);
        write_reg(REG_CARE_MASK, 64'hFFFF_FFFF_FF00_0001);
        write_reg(REG_SPARE_6, '1);
        write_reg(REG_SPARE_7, '1);
        cfg_write <= 1'b0;
        send_byte(8'hA5, 1'b1);
        settle();

        // middle byte is a wildcard; address wraps; words after the hit are dropped
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_0033_2211);
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        write_reg(REG_CARE_MASK, 64'h0000_0000_0000_0005);
        write_reg(REG_BASE_ADDRESS, '1);
        cfg_write <= 1'b0;
        send_byte(8'h00, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h42, 1'b1);
        settle();

        // zero signature against the cleared window: no hit before three words
        write_reg(REG_PATTERN_LOW, '0);
        write_reg(REG_CARE_MASK, 64'h0000_0000_00FF_FFFF);
        cfg_write <= 1'b0;
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            settle();
            pick_settings(phases);
            steady = ($urandom_range(0, 3) == 0);
            if (phases == 1)
            begin
                // one result word per region: the output queue fills during the stall
                hold_req = 1'b1;
                repeat (12) send_byte(8'($urandom), 1'b1);
            end
            repeat (4) send_region();
            phases++;
        end
        settle();

        $display("Covered %0d words (%0d scanned) in %0d regions over %0d settings.",
                 items_sent, scanned_count, regions_sent, phases);
        $display("Checked %0d result words, %0d of them hits.", result_count, match_count);
        if (pending != 0)
            $error("%0d expected result words never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
